// File: hw/rtl/sdfs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sdfs_pkg
// Shared types, codes and helpers for the separator field splitter.
// ----------------------------------------------------------------------------
package sdfs_pkg;

	// Longest separator and width of the field counter.
	localparam int SEP_MAX = 8;
	localparam int FC_W    = 16;
	localparam logic [FC_W-1:0] FIELD_MAX = {FC_W{1'b1}};

	// Sequence seen by one item: the window plus the new byte.
	localparam int SEQ_N = SEP_MAX + 1;

	// Job queue between front and back.
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// Result kinds.
	localparam logic [1:0] KIND_DATA  = 2'd0;
	localparam logic [1:0] KIND_END   = 2'd1;
	localparam logic [1:0] KIND_TRUNC = 2'd2;

	// Configuration register indexes.
	localparam logic [1:0] REG_SEP   = 2'd0;
	localparam logic [1:0] REG_LEN   = 2'd1;
	localparam logic [1:0] REG_LIMIT = 2'd2;

	// Work handed from the front to the back for one item.
	typedef struct packed {
		logic [SEQ_N-1:0][7:0] seq;       // bytes in stream order, oldest at 0
		logic [3:0]            rel;       // leading bytes released as data
		logic                  has_end;   // separator matched
		logic                  has_trunc; // field limit reached
		logic                  has_final; // stream end closes a field
		logic [15:0]           fn0;       // field number before the match
		logic [15:0]           fn1;       // field number after the match
	} job_t;

	// Saturate the field counter to the 16-bit result field.
	function automatic logic [15:0] sat_fn(input logic [FC_W-1:0] v);
		logic [31:0] w;
		w = 32'(v);
		return (w > 32'd65535) ? 16'hFFFF : w[15:0];
	endfunction

	// Clamp the separator length to 1..SEP_MAX.
	function automatic logic [3:0] clamp_len(input logic [3:0] v);
		logic [3:0] r;
		r = v;
		if (v == 4'd0) r = 4'd1;
		if (v > 4'(SEP_MAX)) r = 4'(SEP_MAX);
		return r;
	endfunction

	// Number of results a job produces.
	function automatic logic [3:0] job_results(input job_t j);
		return j.rel + 4'(j.has_end) + 4'(j.has_trunc) + 4'(j.has_final);
	endfunction

endpackage
`default_nettype wire

// File: hw/rtl/sdfs_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sdfs_front
// Holds the configuration and the lookahead window, compares the window with
// the separator and turns each accepted byte that causes results into a job.
// ----------------------------------------------------------------------------
module sdfs_front (
	input  wire              clk,
	input  wire              arst_n,
	// configuration write channel
	input  wire              cfg_valid,
	output logic             cfg_ready,
	input  wire  [1:0]       cfg_index,
	input  wire  [63:0]      cfg_data,
	// byte input
	input  wire              in_valid,
	output logic             in_ready,
	input  wire  [7:0]       in_byte,
	input  wire              in_last,
	// job output to the queue
	output logic             job_valid,
	input  wire              job_ready,
	output sdfs_pkg::job_t   job
);

	logic [63:0]          sep_q;
	logic [3:0]           len_raw_q;
	logic [15:0]          limit_q;
	logic [7:0]           win_q [sdfs_pkg::SEP_MAX];
	logic [3:0]           cnt_q;
	logic [sdfs_pkg::FC_W-1:0] fd_q;
	logic                 trunc_q;

	logic [3:0]           len;
	logic [sdfs_pkg::SEQ_N-1:0][7:0] seq;
	logic [3:0]           n_tot;
	logic                 full;
	logic [3:0]           base;
	logic                 mis;
	logic                 match;
	logic [sdfs_pkg::FC_W-1:0] fd_inc;
	logic                 trunc;
	logic [3:0]           rel;
	logic [3:0]           cnt_d;
	logic [7:0]           win_d [sdfs_pkg::SEP_MAX];
	logic [4:0]           cidx;
	logic [4:0]           widx;
	logic [7:0]           cand;
	logic                 accept;

	assign cfg_ready = 1'b1;
	assign len       = sdfs_pkg::clamp_len(len_raw_q);

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sep_q     <= 64'd44;
			len_raw_q <= 4'd1;
			limit_q   <= 16'd0;
		end else if (cfg_valid) begin
			case (cfg_index)
				sdfs_pkg::REG_SEP:   sep_q     <= cfg_data;
				sdfs_pkg::REG_LEN:   len_raw_q <= cfg_data[3:0];
				sdfs_pkg::REG_LIMIT: limit_q   <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// Window contents followed by the new byte.
	always_comb begin
		for (int i = 0; i < sdfs_pkg::SEQ_N; i++) begin
			if (4'(i) < cnt_q) seq[i] = win_q[3'(i)];
			else if (4'(i) == cnt_q) seq[i] = in_byte;
			else seq[i] = 8'd0;
		end
	end

	// Separator compare over the newest len bytes.
	always_comb begin
		n_tot = cnt_q + 4'd1;
		full  = (n_tot >= len);
		base  = full ? (n_tot - len) : 4'd0;
		mis   = 1'b0;
		for (int i = 0; i < sdfs_pkg::SEP_MAX; i++) begin
			cidx = 5'(base) + 5'(i);
			cand = (cidx <= 5'(sdfs_pkg::SEP_MAX)) ? seq[cidx[3:0]] : 8'd0;
			if ((4'(i) < len) && (cand != sep_q[8*i +: 8])) mis = 1'b1;
		end
		match = full && !mis;
	end

	// Field count, limit check and the number of bytes released.
	always_comb begin
		fd_inc = (fd_q == sdfs_pkg::FIELD_MAX) ? fd_q : fd_q + 1'b1;
		trunc  = match && (limit_q != 16'd0) && (32'(fd_inc) >= 32'(limit_q));
		if (in_last && !match) rel = n_tot;
		else if (full && !match) rel = base + 4'd1;
		else rel = base;
		cnt_d = (match || in_last) ? 4'd0 : (n_tot - rel);
		for (int i = 0; i < sdfs_pkg::SEP_MAX; i++) begin
			widx     = 5'(rel) + 5'(i);
			win_d[i] = (widx <= 5'(sdfs_pkg::SEP_MAX)) ? seq[widx[3:0]] : 8'd0;
		end
	end

	// Job for the back end.
	always_comb begin
		job.seq       = seq;
		job.rel       = rel;
		job.has_end   = match;
		job.has_trunc = trunc;
		job.has_final = in_last && !trunc;
		job.fn0       = sdfs_pkg::sat_fn(fd_q);
		job.fn1       = match ? sdfs_pkg::sat_fn(fd_inc) : sdfs_pkg::sat_fn(fd_q);
	end

	// A truncated stream is swallowed without needing queue space.
	assign in_ready  = trunc_q || job_ready;
	assign accept    = in_valid && in_ready;
	assign job_valid = in_valid && !trunc_q && (sdfs_pkg::job_results(job) != 4'd0);

	// Stream state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= 4'd0;
			fd_q    <= '0;
			trunc_q <= 1'b0;
		end else if (accept) begin
			if (trunc_q) begin
				if (in_last) begin
					cnt_q   <= 4'd0;
					fd_q    <= '0;
					trunc_q <= 1'b0;
				end
			end else begin
				cnt_q <= cnt_d;
				if (in_last) begin
					fd_q    <= '0;
					trunc_q <= 1'b0;
				end else if (match) begin
					fd_q    <= fd_inc;
					trunc_q <= trunc;
				end
			end
		end
	end

	// Window bytes.
	always_ff @(posedge clk) begin
		if (accept && !trunc_q) begin
			for (int i = 0; i < sdfs_pkg::SEP_MAX; i++) win_q[i] <= win_d[i];
		end
	end

endmodule
`default_nettype wire

// File: hw/rtl/sdfs_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sdfs_queue
// Short job queue that lets the front and the back end stall independently.
// ----------------------------------------------------------------------------
module sdfs_queue (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              wr_valid,
	output logic             wr_ready,
	input  sdfs_pkg::job_t   wr_job,
	output logic             rd_valid,
	input  wire              rd_ready,
	output sdfs_pkg::job_t   rd_job
);

	sdfs_pkg::job_t                entry_q [sdfs_pkg::QDEPTH];
	logic [sdfs_pkg::QPTR_W-1:0]   wr_ptr_q;
	logic [sdfs_pkg::QPTR_W-1:0]   rd_ptr_q;
	logic [sdfs_pkg::QCNT_W-1:0]   count_q;
	logic                          push;
	logic                          pop;

	assign wr_ready = (count_q != sdfs_pkg::QCNT_W'(sdfs_pkg::QDEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_job   = entry_q[rd_ptr_q];
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop) count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

	// Storage.
	always_ff @(posedge clk) begin
		if (push) entry_q[wr_ptr_q] <= wr_job;
	end

endmodule
`default_nettype wire

// File: hw/rtl/sdfs_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sdfs_back
// Takes jobs from the queue and issues results one per cycle while res_ready
// is high: released data first, then field end, truncation, final field end.
// ----------------------------------------------------------------------------
module sdfs_back (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              job_valid,
	output logic             job_ready,
	input  sdfs_pkg::job_t   job,
	output logic             res_valid,
	input  wire              res_ready,
	output logic [1:0]       res_kind,
	output logic [7:0]       res_byte,
	output logic [15:0]      res_fn,
	output logic             res_last,
	output logic             res_complete
);

	sdfs_pkg::job_t cur_q;
	logic           busy_q;
	logic [3:0]     idx_q;
	logic [3:0]     nres;
	logic [3:0]     off;
	logic [3:0]     off2;
	logic           step_last;
	logic           load;

	assign nres      = sdfs_pkg::job_results(cur_q);
	assign step_last = (idx_q == nres - 4'd1);
	assign res_valid = busy_q;
	assign res_last  = step_last;
	assign load      = job_valid && (!busy_q || (res_ready && step_last));
	assign job_ready = load;

	// Pick the result at the current step.
	always_comb begin
		off          = idx_q - cur_q.rel;
		off2         = off - 4'(cur_q.has_end);
		res_byte     = 8'd0;
		res_complete = 1'b0;
		if (idx_q < cur_q.rel) begin
			res_kind = sdfs_pkg::KIND_DATA;
			res_byte = cur_q.seq[idx_q];
			res_fn   = cur_q.fn0;
		end else if (cur_q.has_end && off == 4'd0) begin
			res_kind = sdfs_pkg::KIND_END;
			res_fn   = cur_q.fn0;
		end else if (cur_q.has_trunc && off2 == 4'd0) begin
			res_kind = sdfs_pkg::KIND_TRUNC;
			res_fn   = cur_q.fn1;
		end else begin
			res_kind     = sdfs_pkg::KIND_END;
			res_fn       = cur_q.fn1;
			res_complete = 1'b1;
		end
	end

	// Step control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= 4'd0;
		end else if (load) begin
			busy_q <= 1'b1;
			idx_q  <= 4'd0;
		end else if (busy_q && res_ready) begin
			if (step_last) busy_q <= 1'b0;
			idx_q <= idx_q + 4'd1;
		end
	end

	// Current job.
	always_ff @(posedge clk) begin
		if (load) cur_q <= job;
	end

endmodule
`default_nettype wire

// File: hw/rtl/substring_delimiter_field_splitter.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// substring_delimiter_field_splitter
// Splits a byte stream into fields at matches of a separator of 1 to 8 bytes.
// ----------------------------------------------------------------------------
// A byte request is taken whenever the job queue has room (and always while a
// truncated stream is being dropped); the front end compares the newest len
// bytes of the window and the new byte with the separator as it is taken.
// Results leave at one per cycle from the back end while the output is ready;
// a byte that causes no results puts no job in the queue. A four-entry job
// queue sits between the two, and a byte's job passes through a queue entry
// and the back end's job register before its first result. Configuration
// writes are always accepted and must only be made while the block is idle.
module substring_delimiter_field_splitter (
	input  wire         clk,
	input  wire         arst_n,
	// configuration write channel
	input  wire         cfg_valid,
	output logic        cfg_ready,
	input  wire  [1:0]  cfg_index,
	input  wire  [63:0] cfg_data,
	// byte input
	input  wire         s_axis_tvalid,
	output logic        s_axis_tready,
	input  wire  [7:0]  s_axis_tdata,   // [7:0] in_byte
	input  wire         s_axis_tlast,   // in_last
	// result output
	output logic        m_axis_tvalid,
	input  wire         m_axis_tready,
	output logic [31:0] m_axis_tdata,   // [7:0] out_byte, [23:8] field_number,
	                                    // [24] stream_complete, [31:25] zero
	output logic [1:0]  m_axis_tuser,   // [1:0] out_kind
	output logic        m_axis_tlast    // run_last
);

	logic           fq_valid;
	logic           fq_ready;
	sdfs_pkg::job_t fq_job;
	logic           qb_valid;
	logic           qb_ready;
	sdfs_pkg::job_t qb_job;
	logic [7:0]     res_byte;
	logic [15:0]    res_fn;
	logic           res_complete;

	sdfs_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_byte   (s_axis_tdata),
		.in_last   (s_axis_tlast),
		.job_valid (fq_valid),
		.job_ready (fq_ready),
		.job       (fq_job)
	);

	sdfs_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (fq_valid),
		.wr_ready (fq_ready),
		.wr_job   (fq_job),
		.rd_valid (qb_valid),
		.rd_ready (qb_ready),
		.rd_job   (qb_job)
	);

	sdfs_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.job_valid    (qb_valid),
		.job_ready    (qb_ready),
		.job          (qb_job),
		.res_valid    (m_axis_tvalid),
		.res_ready    (m_axis_tready),
		.res_kind     (m_axis_tuser),
		.res_byte     (res_byte),
		.res_fn       (res_fn),
		.res_last     (m_axis_tlast),
		.res_complete (res_complete)
	);

	// Pack the result fields.
	assign m_axis_tdata = {7'd0, res_complete, res_fn, res_byte};

endmodule
`default_nettype wire

// File: hw/rtl/sdfs_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sdfs_checker
// Port-level checks on the result stream of the field splitter.
// ----------------------------------------------------------------------------
module sdfs_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        m_axis_tvalid,
	input wire        m_axis_tready,
	input wire [31:0] m_axis_tdata,
	input wire [1:0]  m_axis_tuser,
	input wire        m_axis_tlast
);

	// A stalled result holds its contents.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
			&& $stable(m_axis_tlast))
		else $error("result changed while stalled");

	// Only a final field end marks a complete stream, and it ends its run.
	a_complete: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[24] |->
			m_axis_tuser == sdfs_pkg::KIND_END && m_axis_tlast)
		else $error("stream complete on a wrong result");

	// Truncation is always the last result of its byte.
	a_trunc_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser == sdfs_pkg::KIND_TRUNC |-> m_axis_tlast)
		else $error("truncation not last in run");

	// Non-data results carry a zero byte.
	a_zero_byte: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser != sdfs_pkg::KIND_DATA |->
			m_axis_tdata[7:0] == 8'd0)
		else $error("byte set on non-data result");

endmodule

bind substring_delimiter_field_splitter sdfs_checker u_sdfs_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser),
	.m_axis_tlast  (m_axis_tlast)
);
`default_nettype wire

// File: tb/tb_substring_delimiter_field_splitter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_substring_delimiter_field_splitter
// Self-checking bench for the separator field splitter. A clocked driver
// sends byte requests from a queue, and a clocked monitor checks every result
// against a local predictor of the splitting rules. The run covers directed
// corner cases and then randomised phases over several separator, length and
// limit settings, with random stalls on both sides.
// ----------------------------------------------------------------------------
module tb_substring_delimiter_field_splitter;

	localparam int QUIET_LIMIT  = 3000;
	localparam int HOLD_CYCLES  = 400;
	localparam int DRAIN_CYCLES = 10;
	localparam int PHASE_BYTES  = 44;
	localparam int SHOWN_ERRORS = 10;

	typedef struct {
		logic [7:0] data;
		logic       last;
	} stream_byte_t;

	typedef struct {
		logic [1:0]  kind;
		logic [7:0]  data;
		logic [15:0] field_no;
		logic        run_last;
		logic        complete;
	} split_result_t;

	logic        clk    = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = sdfs_pkg::REG_SEP;
	logic [63:0] cfg_data  = '0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata  = '0;
	logic        s_axis_tlast  = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;
	logic [1:0]  m_axis_tuser;
	logic        m_axis_tlast;

	substring_delimiter_field_splitter DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	// 20 ns clock.
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Predictor state: registers as last written, and the splitter's own state.
	logic [63:0] sep_bytes    = 64'd44;
	logic [3:0]  sep_len_raw  = 4'd1;
	logic [15:0] field_limit  = 16'd0;
	logic [7:0]  window [sdfs_pkg::SEP_MAX];
	int          window_fill  = 0;
	logic [15:0] fields_done  = '0;
	logic        dropping     = 1'b0;

	stream_byte_t  byte_queue [$];
	split_result_t split_results [$];
	split_result_t step_results [$];

	int in_gap_pct  = 30;
	int out_gap_pct = 30;
	int hold_seq    = 0;
	int mismatches  = 0;

	// Separator length in use, with out-of-range settings clamped.
	function automatic int sep_len_used();
		if (sep_len_raw == 4'd0)
			return 1;
		if (int'(sep_len_raw) > sdfs_pkg::SEP_MAX)
			return sdfs_pkg::SEP_MAX;
		return int'(sep_len_raw);
	endfunction

	// Idle length after one request: mostly none, a few short, rarely long.
	function automatic int gap_len(input int pct);
		if ($urandom_range(99) >= pct)
			return 0;
		if ($urandom_range(9) == 0)
			return $urandom_range(40, 10);
		return $urandom_range(3, 1);
	endfunction

	task automatic add_result(input logic [1:0] kind, input logic [7:0] data,
			input logic complete);
		split_result_t r;
		r.kind     = kind;
		r.data     = data;
		r.field_no = fields_done;
		r.run_last = 1'b0;
		r.complete = complete;
		step_results.insert(step_results.size(), r);
	endtask

	// The oldest window byte leaves as field data.
	task automatic release_oldest();
		add_result(sdfs_pkg::KIND_DATA, window[0], 1'b0);
		for (int i = 1; i < window_fill; i++)
			window[i-1] = window[i];
		window_fill--;
	endtask

	task automatic close_stream();
		window_fill = 0;
		fields_done = '0;
		dropping    = 1'b0;
	endtask

	// Work out the results that one accepted byte causes.
	task automatic split_byte(input logic [7:0] b, input logic last);
		int   len;
		logic hit;
		step_results.delete();
		len = sep_len_used();
		if (dropping) begin
			if (last)
				close_stream();
			return;
		end
		if (window_fill >= sdfs_pkg::SEP_MAX)
			release_oldest();
		window[window_fill] = b;
		window_fill++;
		// A shortened separator pushes surplus bytes out first.
		while (window_fill > len)
			release_oldest();
		if (window_fill == len) begin
			hit = 1'b1;
			for (int i = 0; i < len; i++)
				if (window[i] != sep_bytes[8*i +: 8])
					hit = 1'b0;
			if (hit) begin
				add_result(sdfs_pkg::KIND_END, 8'd0, 1'b0);
				window_fill = 0;
				if (fields_done != sdfs_pkg::FIELD_MAX)
					fields_done++;
				if (field_limit != 0 && fields_done >= field_limit) begin
					add_result(sdfs_pkg::KIND_TRUNC, 8'd0, 1'b0);
					dropping = 1'b1;
				end
			end else if (!last) begin
				release_oldest();
			end
		end
		// Stream end flushes a partial window and closes the final field.
		if (last) begin
			if (!dropping) begin
				while (window_fill > 0)
					release_oldest();
				add_result(sdfs_pkg::KIND_END, 8'd0, 1'b1);
			end
			close_stream();
		end
		if (step_results.size() > 0)
			step_results[$].run_last = 1'b1;
		foreach (step_results[i])
			split_results.insert(split_results.size(), step_results[i]);
	endtask

	// Byte driver: one request at a time from the queue, with random gaps.
	always @(posedge clk) begin : drive_bytes
		stream_byte_t nxt;
		int           send_gap;
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= '0;
			s_axis_tlast  <= 1'b0;
			send_gap = 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				split_byte(s_axis_tdata, s_axis_tlast);
			if (!s_axis_tvalid || s_axis_tready) begin
				if (send_gap > 0) begin
					send_gap--;
					s_axis_tvalid <= 1'b0;
				end else if (byte_queue.size() > 0) begin
					nxt = byte_queue.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tdata  <= nxt.data;
					s_axis_tlast  <= nxt.last;
					send_gap = gap_len(in_gap_pct);
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// Result monitor: checks each result and throttles the ready line.
	always @(posedge clk) begin : watch_results
		split_result_t want;
		int            stall;
		int            hold_seen;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			stall     = 0;
			hold_seen = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (split_results.size() == 0) begin
					mismatches++;
					if (mismatches <= SHOWN_ERRORS)
						$display("unexpected result: kind %0d data %02h tdata %08h",
							m_axis_tuser, m_axis_tdata[7:0], m_axis_tdata);
				end else begin
					want = split_results.pop_front();
					if (m_axis_tuser !== want.kind || m_axis_tdata[7:0] !== want.data ||
							m_axis_tdata[23:8] !== want.field_no ||
							m_axis_tdata[24] !== want.complete ||
							m_axis_tdata[31:25] !== 7'd0 ||
							m_axis_tlast !== want.run_last) begin
						mismatches++;
						if (mismatches <= SHOWN_ERRORS)
							$display("mismatch: expected kind %0d data %02h field %0d",
								want.kind, want.data, want.field_no,
								" complete %0b last %0b,", want.complete, want.run_last,
								" got kind %0d data %02h field %0d", m_axis_tuser,
								m_axis_tdata[7:0], m_axis_tdata[23:8],
								" complete %0b last %0b pad %02h", m_axis_tdata[24],
								m_axis_tlast, m_axis_tdata[31:25]);
					end
				end
			end
			// A new hold-off request starts a long stall.
			if (hold_seen != hold_seq) begin
				hold_seen = hold_seq;
				stall = HOLD_CYCLES;
			end
			if (stall > 0) begin
				stall--;
				m_axis_tready <= 1'b0;
			end else begin
				stall = gap_len(out_gap_pct);
				m_axis_tready <= (stall == 0);
			end
		end
	end

	// Watchdog: ends the run when nothing moves for too long.
	always @(posedge clk) begin : watchdog
		int quiet_cycles;
		if (!arst_n) begin
			quiet_cycles = 0;
		end else if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
				(cfg_valid && cfg_ready)) begin
			quiet_cycles = 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("status: fail");
			$finish;
		end else begin
			quiet_cycles++;
		end
	end

	task automatic add_byte(input logic [7:0] b, input logic last);
		stream_byte_t s;
		s.data = b;
		s.last = last;
		byte_queue.insert(byte_queue.size(), s);
	endtask

	// One stream of random content, rich in whole and partial separators.
	task automatic queue_stream(input int n_bytes);
		int len;
		int k;
		int cut;
		int r;
		len = sep_len_used();
		k = 0;
		while (k < n_bytes) begin
			r = $urandom_range(99);
			if (r < 35 && k + len <= n_bytes) begin
				for (int j = 0; j < len; j++)
					add_byte(sep_bytes[8*j +: 8], k + j == n_bytes - 1);
				k += len;
			end else if (r < 50 && len > 1) begin
				cut = $urandom_range(len - 1, 1);
				for (int j = 0; j < cut && k < n_bytes; j++) begin
					add_byte(sep_bytes[8*j +: 8], k == n_bytes - 1);
					k++;
				end
			end else begin
				if ($urandom_range(1))
					add_byte(sep_bytes[8*$urandom_range(len - 1) +: 8], k == n_bytes - 1);
				else
					add_byte(8'($urandom), k == n_bytes - 1);
				k++;
			end
		end
	endtask

	// Register write request; the predictor takes the value on acceptance.
	task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			sdfs_pkg::REG_SEP:   sep_bytes   = val;
			sdfs_pkg::REG_LEN:   sep_len_raw = val[3:0];
			sdfs_pkg::REG_LIMIT: field_limit = val[15:0];
			default: ;
		endcase
	endtask

	// Wait until every request has gone in and every result has come out.
	task automatic wait_drained();
		while (byte_queue.size() != 0 || s_axis_tvalid || split_results.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// One random phase under a given register setting.
	task automatic run_phase(input logic [63:0] sep, input logic [3:0] len,
			input logic [15:0] limit, input int in_pct, input int out_pct,
			input logic hold);
		int remaining;
		int n;
		wait_drained();
		in_gap_pct  = in_pct;
		out_gap_pct = out_pct;
		write_reg(sdfs_pkg::REG_SEP, sep);
		write_reg(sdfs_pkg::REG_LEN, {$urandom, 28'($urandom), len});
		write_reg(sdfs_pkg::REG_LIMIT, {$urandom, 16'($urandom), limit});
		if (hold)
			hold_seq <= hold_seq + 1;
		remaining = PHASE_BYTES;
		while (remaining > 0) begin
			n = ($urandom_range(7) == 0) ? $urandom_range(30, 16) : $urandom_range(12, 1);
			if (n > remaining)
				n = remaining;
			queue_stream(n);
			remaining -= n;
		end
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Reset setting: NUL and 0xFF as data, an empty field, a lone separator.
		add_byte(8'h00, 1'b0);
		add_byte(8'hFF, 1'b0);
		add_byte(8'h2C, 1'b0);
		add_byte(8'h2C, 1'b0);
		add_byte(8'h41, 1'b1);
		add_byte(8'h2C, 1'b1);

		// Three-byte separator: partial match at stream end, then an overlap.
		wait_drained();
		write_reg(sdfs_pkg::REG_SEP, 64'h0000_0000_0063_6261);
		write_reg(sdfs_pkg::REG_LEN, 64'd3);
		add_byte(8'h61, 1'b0);
		add_byte(8'h62, 1'b1);
		add_byte(8'h61, 1'b0);
		add_byte(8'h61, 1'b0);
		add_byte(8'h62, 1'b0);
		add_byte(8'h63, 1'b0);
		add_byte(8'h78, 1'b1);

		// Separator shortened while the window still holds bytes.
		add_byte(8'h78, 1'b0);
		add_byte(8'h61, 1'b0);
		add_byte(8'h62, 1'b0);
		wait_drained();
		write_reg(sdfs_pkg::REG_LEN, 64'd1);
		add_byte(8'h62, 1'b0);
		add_byte(8'h61, 1'b1);

		// Field limit: truncation mid-stream, then on the final byte.
		wait_drained();
		write_reg(sdfs_pkg::REG_LIMIT, {$urandom, 16'($urandom), 16'd2});
		add_byte(8'h61, 1'b0);
		add_byte(8'h71, 1'b0);
		add_byte(8'h61, 1'b0);
		add_byte(8'h72, 1'b0);
		add_byte(8'h61, 1'b0);
		add_byte(8'h73, 1'b1);
		add_byte(8'h61, 1'b0);
		add_byte(8'h61, 1'b1);

		// Random phases over the extremes and a spread of settings.
		run_phase(64'h0, 4'd8, 16'd0, 30, 30, 1'b0);
		run_phase({64{1'b1}}, 4'd15, 16'hFFFF, 20, 40, 1'b0);
		run_phase({$urandom, $urandom}, 4'd0, 16'd1, 40, 20, 1'b0);
		run_phase({$urandom, $urandom}, 4'd2, 16'd3, 30, 30, 1'b0);
		run_phase({$urandom, $urandom}, 4'd5, 16'd0, 10, 10, 1'b1);
		run_phase({$urandom, $urandom}, 4'd8, 16'd0, 0, 0, 1'b0);
		run_phase({$urandom, $urandom}, 4'd4, 16'd2, 50, 50, 1'b0);
		run_phase({$urandom, $urandom}, 4'(8 + $urandom_range(7)), 16'd0, 30, 30, 1'b0);

		wait_drained();
		if (mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
